FILE: sv/fcd_pkg.sv
// fcd_pkg: shared types and constants for the fsk cycle count demodulator
// no dependencies; used by the channel interfaces and the top level
package fcd_pkg;

  // default parameter values
  localparam int SAMPLE_BITS_DEF = 10;
  localparam int WORD_BITS_DEF   = 32;

  // fixed field widths
  localparam int THR_W      = 10;
  localparam int WIN_W      = 20;
  localparam int TIME_W     = 32;
  localparam int BPF_W      = 6;
  localparam int OUT_WORD_W = 32;
  localparam int CNT_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int STATUS_W   = 2;
  // width for comparing bit counts against the target (holds 64)
  localparam int TGT_CMP_W  = 8;

  // register reset values
  localparam logic [THR_W-1:0]  SLOPE_RST    = THR_W'(150);
  localparam logic [WIN_W-1:0]  WINDOW_RST   = WIN_W'(9700);
  localparam logic [TIME_W-1:0] START_TO_RST = TIME_W'(1000000);
  localparam logic [TIME_W-1:0] GAP_TO_RST   = TIME_W'(300000);
  localparam logic [BPF_W-1:0]  BITS_RST     = BPF_W'(16);

  // cycle counts that map onto symbols without clamping
  localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(5);

  localparam logic [OUT_WORD_W-1:0] GAP_WORD = OUT_WORD_W'(3);

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_NO_SIGNAL = 2'd1,
    ST_GAP       = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLOPE    = 3'd0,
    REG_WINDOW   = 3'd1,
    REG_START_TO = 3'd2,
    REG_GAP_TO   = 3'd3,
    REG_BITS     = 3'd4
  } cfg_idx_t;

endpackage

FILE: sv/fcd_in_if.sv
// fcd_in_if: sample channel into the demodulator, valid/ready handshake
// depends on fcd_pkg
interface fcd_in_if #(
  parameter int SAMPLE_BITS = fcd_pkg::SAMPLE_BITS_DEF
);
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [SAMPLE_BITS-1:0]   reading;
  logic [fcd_pkg::TIME_W-1:0] now_us;

  modport source (output valid, output action, output reading, output now_us, input ready);
  modport sink   (input valid, input action, input reading, input now_us, output ready);
endinterface

FILE: sv/fcd_out_if.sv
// fcd_out_if: result channel out of the demodulator, valid/ready handshake
// depends on fcd_pkg
interface fcd_out_if;
  logic                           valid;
  logic                           ready;
  logic [fcd_pkg::STATUS_W-1:0]   status;
  logic [fcd_pkg::OUT_WORD_W-1:0] word;
  logic                           clamped;

  modport source (output valid, output status, output word, output clamped, input ready);
  modport sink   (input valid, input status, input word, input clamped, output ready);
endinterface

FILE: sv/fcd_cfg_if.sv
// fcd_cfg_if: register write channel, index and data with valid/ready
// depends on fcd_pkg
interface fcd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fcd_pkg::CFG_IDX_W-1:0]  index;
  logic [fcd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/fsk_cycle_count_demodulator.sv
// fsk_cycle_count_demodulator: 4-ary fsk receiver counting signal cycles per symbol
// depends on fcd_pkg, fcd_in_if, fcd_out_if, fcd_cfg_if

// Takes one timestamped ADC sample item per clock. Each item lands in an input
// register, and from there one pass of compare and count logic updates the
// frame state and, when a frame ends, loads the result register. The only
// thing that slows intake is a result left waiting in the output register:
// while it waits, the item in the input register is held whether or not it
// ends a frame, so at most one more item is taken until the consumer accepts
// the result. Items keep flowing at one per cycle as long as the consumer
// takes results. A start item
// opens a frame; rises and falls beyond slope_threshold count cycles, each
// symbol window turns its count into two bits, and the word is emitted with
// status 0 once the target bit count is reached (status 1 on a start timeout,
// status 2 with word 3 on a gap timeout). Register writes are taken at any time
// but must only be issued while the block is idle.
module fsk_cycle_count_demodulator #(
  parameter int SAMPLE_BITS = fcd_pkg::SAMPLE_BITS_DEF,
  parameter int WORD_BITS   = fcd_pkg::WORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  fcd_in_if.sink    in_if,
  fcd_out_if.source out_if,
  fcd_cfg_if.sink   cfg_if
);
  import fcd_pkg::*;

  localparam int CW      = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
  localparam int TGT_MAX = (WORD_BITS < 63) ? WORD_BITS : 63;
  localparam int BR_W    = $clog2(TGT_MAX + 2);

  // configuration registers
  logic [THR_W-1:0]  slope_thr_r;
  logic [WIN_W-1:0]  window_r;
  logic [TIME_W-1:0] start_to_r;
  logic [TIME_W-1:0] gap_to_r;
  logic [BPF_W-1:0]  bits_pf_r;

  // input register stage
  logic                   s1_valid_r, s1_valid_nxt;
  logic                   s1_action_r;
  logic [SAMPLE_BITS-1:0] s1_reading_r;
  logic [TIME_W-1:0]      s1_now_r;

  // frame state
  logic                   active_r, active_nxt;
  logic                   in_cycle_r, in_cycle_nxt;
  logic                   seen_r, seen_nxt;
  logic                   clamp_seen_r, clamp_seen_nxt;
  logic [SAMPLE_BITS-1:0] prev_r, prev_nxt;
  logic [SAMPLE_BITS-1:0] peak_r, peak_nxt;
  logic [CNT_W-1:0]       cycle_cnt_r, cycle_cnt_nxt;
  logic [BR_W-1:0]        bits_rx_r, bits_rx_nxt;
  logic [TIME_W-1:0]      win_start_r, win_start_nxt;
  logic [TIME_W-1:0]      frame_start_r, frame_start_nxt;
  logic [TIME_W-1:0]      last_sym_r, last_sym_nxt;
  logic [WORD_BITS-1:0]   shift_r, shift_nxt;

  // result register
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, res_status;
  logic [OUT_WORD_W-1:0] out_word_r, res_word;
  logic                  out_clamped_r, res_clamped;
  logic                  res_emit;

  logic in_acc, s2_fire;
  logic [TGT_CMP_W-1:0] target;

  assign in_acc       = in_if.valid & in_if.ready;
  assign s2_fire      = s1_valid_r & (~out_valid_r | out_if.ready);
  assign in_if.ready  = ~s1_valid_r | s2_fire;
  assign cfg_if.ready = 1'b1;

  assign out_if.valid   = out_valid_r;
  assign out_if.status  = out_status_r;
  assign out_if.word    = out_word_r;
  assign out_if.clamped = out_clamped_r;

  assign target = ({2'b00, bits_pf_r} < TGT_CMP_W'(WORD_BITS)) ?
                  {2'b00, bits_pf_r} : TGT_CMP_W'(WORD_BITS);

  assign s1_valid_nxt  = in_acc | (s1_valid_r & ~s2_fire);
  assign out_valid_nxt = (s2_fire & res_emit) | (out_valid_r & ~out_if.ready);

  // per-item frame update
  always_comb begin
    logic              rise, fall;
    logic [CW-1:0]     rdg_x, prev_x, peak_x, thr_x;
    logic [1:0]        sym;
    logic [TIME_W-1:0] now;

    active_nxt      = active_r;
    in_cycle_nxt    = in_cycle_r;
    seen_nxt        = seen_r;
    clamp_seen_nxt  = clamp_seen_r;
    prev_nxt        = prev_r;
    peak_nxt        = peak_r;
    cycle_cnt_nxt   = cycle_cnt_r;
    bits_rx_nxt     = bits_rx_r;
    win_start_nxt   = win_start_r;
    frame_start_nxt = frame_start_r;
    last_sym_nxt    = last_sym_r;
    shift_nxt       = shift_r;
    res_emit        = 1'b0;
    res_status      = ST_DONE;
    res_word        = '0;
    res_clamped     = 1'b0;
    rise            = 1'b0;
    fall            = 1'b0;
    sym             = 2'd0;
    now             = s1_now_r;
    rdg_x           = CW'(s1_reading_r);
    prev_x          = CW'(prev_r);
    peak_x          = '0;
    thr_x           = CW'(slope_thr_r);

    if (s1_action_r) begin
      active_nxt      = 1'b1;
      in_cycle_nxt    = 1'b0;
      seen_nxt        = 1'b0;
      clamp_seen_nxt  = 1'b0;
      prev_nxt        = s1_reading_r;
      peak_nxt        = '0;
      cycle_cnt_nxt   = '0;
      bits_rx_nxt     = '0;
      win_start_nxt   = now;
      frame_start_nxt = now;
      last_sym_nxt    = now;
      shift_nxt       = '0;
      if (target == '0) begin
        res_emit   = 1'b1;
        active_nxt = 1'b0;
      end
    end else if (active_r) begin
      if (!seen_r && (now - frame_start_r) > start_to_r) begin
        res_emit   = 1'b1;
        res_status = ST_NO_SIGNAL;
        active_nxt = 1'b0;
      end else if (seen_r && (now - last_sym_r) > gap_to_r) begin
        res_emit    = 1'b1;
        res_status  = ST_GAP;
        res_word    = GAP_WORD;
        res_clamped = clamp_seen_r;
        active_nxt  = 1'b0;
      end else begin
        rise = !in_cycle_r && (rdg_x > prev_x) && ((rdg_x - prev_x) > thr_x);
        if (rise) begin
          peak_nxt     = s1_reading_r;
          seen_nxt     = 1'b1;
          in_cycle_nxt = 1'b1;
          if (cycle_cnt_r == '0) begin
            win_start_nxt = now;
          end
        end
        if (s1_reading_r > peak_nxt) begin
          peak_nxt = s1_reading_r;
        end
        peak_x = CW'(peak_nxt);
        fall = in_cycle_nxt && (peak_x > rdg_x) && ((peak_x - rdg_x) > thr_x);
        if (fall) begin
          if (cycle_cnt_nxt != '1) begin
            cycle_cnt_nxt = cycle_cnt_nxt + CNT_W'(1);
          end
          in_cycle_nxt = 1'b0;
        end
        // window over: turn the cycle count into a 2-bit symbol
        if ((now - win_start_nxt) > TIME_W'(window_r) && cycle_cnt_nxt != '0) begin
          in_cycle_nxt = 1'b0;
          if (cycle_cnt_nxt < CNT_MIN) begin
            sym            = 2'd0;
            clamp_seen_nxt = 1'b1;
          end else if (cycle_cnt_nxt > CNT_MAX) begin
            sym            = 2'd3;
            clamp_seen_nxt = 1'b1;
          end else begin
            sym = 2'(cycle_cnt_nxt - CNT_MIN);
          end
          shift_nxt     = {shift_r[WORD_BITS-3:0], sym};
          cycle_cnt_nxt = '0;
          bits_rx_nxt   = bits_rx_r + BR_W'(2);
          last_sym_nxt  = now;
        end
        prev_nxt = s1_reading_r;
        if (TGT_CMP_W'(bits_rx_nxt) >= target) begin
          res_emit    = 1'b1;
          res_status  = ST_DONE;
          res_word    = OUT_WORD_W'(64'(shift_nxt));
          res_clamped = clamp_seen_nxt;
          active_nxt  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slope_thr_r   <= SLOPE_RST;
      window_r      <= WINDOW_RST;
      start_to_r    <= START_TO_RST;
      gap_to_r      <= GAP_TO_RST;
      bits_pf_r     <= BITS_RST;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      active_r      <= 1'b0;
      in_cycle_r    <= 1'b0;
      seen_r        <= 1'b0;
      clamp_seen_r  <= 1'b0;
      prev_r        <= '0;
      peak_r        <= '0;
      cycle_cnt_r   <= '0;
      bits_rx_r     <= '0;
      win_start_r   <= '0;
      frame_start_r <= '0;
      last_sym_r    <= '0;
      shift_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_if.valid) begin
        unique case (cfg_if.index)
          REG_SLOPE:    slope_thr_r <= cfg_if.data[THR_W-1:0];
          REG_WINDOW:   window_r    <= cfg_if.data[WIN_W-1:0];
          REG_START_TO: start_to_r  <= cfg_if.data[TIME_W-1:0];
          REG_GAP_TO:   gap_to_r    <= cfg_if.data[TIME_W-1:0];
          REG_BITS:     bits_pf_r   <= cfg_if.data[BPF_W-1:0];
          default: ;
        endcase
      end
      if (s2_fire) begin
        active_r      <= active_nxt;
        in_cycle_r    <= in_cycle_nxt;
        seen_r        <= seen_nxt;
        clamp_seen_r  <= clamp_seen_nxt;
        prev_r        <= prev_nxt;
        peak_r        <= peak_nxt;
        cycle_cnt_r   <= cycle_cnt_nxt;
        bits_rx_r     <= bits_rx_nxt;
        win_start_r   <= win_start_nxt;
        frame_start_r <= frame_start_nxt;
        last_sym_r    <= last_sym_nxt;
        shift_r       <= shift_nxt;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_action_r  <= in_if.action;
      s1_reading_r <= in_if.reading;
      s1_now_r     <= in_if.now_us;
    end
    if (s2_fire && res_emit) begin
      out_status_r  <= res_status;
      out_word_r    <= res_word;
      out_clamped_r <= res_clamped;
    end
  end

`ifndef SYNTHESIS
  // no-signal results carry an empty word
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_NO_SIGNAL) |-> (out_word_r == '0 && !out_clamped_r))
    else $error("no-signal result with nonzero word or clamp flag");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_GAP) |-> (out_word_r == GAP_WORD))
    else $error("gap timeout result without gap word");

  // any emitted item closes the frame
  assert property (@(posedge clk) disable iff (!rst_n)
    (s2_fire && res_emit) |=> !active_r)
    else $error("frame still active after a result");

  assert property (@(posedge clk) disable iff (!rst_n)
    !bits_rx_r[0])
    else $error("odd received bit count");

  assert property (@(posedge clk) disable iff (!rst_n)
    (cycle_cnt_r != '0) |-> seen_r)
    else $error("cycles counted before any rising edge");

  // a waiting result holds still until taken
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_if.ready) |=>
      (out_valid_r && $stable(out_word_r) && $stable(out_status_r) &&
       $stable(out_clamped_r)))
    else $error("result changed while waiting");
`endif

endmodule

FILE: bench/tb.sv
// tb: self-checking bench for fsk_cycle_count_demodulator, random and directed sample items
// depends on fcd_pkg, fcd_in_if, fcd_out_if, fcd_cfg_if and the demodulator top level
// a local frame decoder predicts every result, which is checked against the result channel
module tb;
  import fcd_pkg::*;

  localparam int RD_W          = SAMPLE_BITS_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_ITEMS   = 30;
  localparam int RAND_PHASES   = 15;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = CFG_IDX_W'(7);

  typedef struct packed {
    logic            act;
    logic [RD_W-1:0] rd;
    logic [TIME_W-1:0] t;
  } sample_item_t;

  typedef struct packed {
    status_t               status;
    logic [OUT_WORD_W-1:0] word;
    logic                  clamped;
  } fsk_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  fcd_in_if #(.SAMPLE_BITS(RD_W)) in_ch ();
  fcd_out_if out_ch ();
  fcd_cfg_if cfg_ch ();

  fsk_cycle_count_demodulator uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // register copies
  logic [THR_W-1:0]  cfg_slope    = SLOPE_RST;
  logic [WIN_W-1:0]  cfg_window   = WINDOW_RST;
  logic [TIME_W-1:0] cfg_start_to = START_TO_RST;
  logic [TIME_W-1:0] cfg_gap_to   = GAP_TO_RST;
  logic [BPF_W-1:0]  cfg_bits     = BITS_RST;

  // frame decoder state
  logic              rx_active = 1'b0;
  logic              rx_in_cycle = 1'b0;
  logic              rx_seen = 1'b0;
  logic              rx_clamp = 1'b0;
  logic [RD_W-1:0]   rx_prev = '0;
  logic [RD_W-1:0]   rx_peak = '0;
  int                rx_count = 0;
  int                rx_bits = 0;
  logic [TIME_W-1:0] rx_win_t = '0;
  logic [TIME_W-1:0] rx_frame_t = '0;
  logic [TIME_W-1:0] rx_last_t = '0;
  logic [OUT_WORD_W-1:0] rx_word = '0;

  sample_item_t sample_queue[$];
  fsk_result_t  frame_results_due[$];
  sample_item_t next_sample;
  fsk_result_t  want;

  int send_idle_pct = 20;
  int recv_idle_pct = 63;
  logic hold_req = 1'b0;
  logic hold_started = 1'b0;
  int hold_left = 0;
  int fail_count = 0;
  int cycle_no = 0;
  int gen_count = 0;
  logic [TIME_W-1:0] t_us = '0;

  function automatic int frame_bits();
    return (int'(cfg_bits) < WORD_BITS_DEF) ? int'(cfg_bits) : WORD_BITS_DEF;
  endfunction

  task automatic end_frame(input status_t st, input logic [OUT_WORD_W-1:0] w, input logic c);
    fsk_result_t r;
    r.status  = st;
    r.word    = w;
    r.clamped = c;
    frame_results_due.push_back(r);
    rx_active = 1'b0;
  endtask

  task automatic track_sample(input logic act, input logic [RD_W-1:0] rd,
                              input logic [TIME_W-1:0] t);
    logic [1:0] sym;
    if (act) begin
      rx_active   = 1'b1;
      rx_in_cycle = 1'b0;
      rx_seen     = 1'b0;
      rx_clamp    = 1'b0;
      rx_prev     = rd;
      rx_peak     = '0;
      rx_count    = 0;
      rx_bits     = 0;
      rx_win_t    = t;
      rx_frame_t  = t;
      rx_last_t   = t;
      rx_word     = '0;
      if (frame_bits() == 0) end_frame(ST_DONE, '0, 1'b0);
      return;
    end
    if (!rx_active) return;
    // both timeouts are checked before the sample is used
    if (!rx_seen && (t - rx_frame_t) > cfg_start_to) begin
      end_frame(ST_NO_SIGNAL, '0, 1'b0);
      return;
    end
    if (rx_seen && (t - rx_last_t) > cfg_gap_to) begin
      end_frame(ST_GAP, GAP_WORD, rx_clamp);
      return;
    end
    if (int'(rd) - int'(rx_prev) > int'(cfg_slope) && !rx_in_cycle) begin
      rx_peak = rd;
      rx_seen = 1'b1;
      if (rx_count == 0) rx_win_t = t;
      rx_in_cycle = 1'b1;
    end
    if (rd > rx_peak) rx_peak = rd;
    if (int'(rx_peak) - int'(rd) > int'(cfg_slope) && rx_in_cycle) begin
      if (rx_count < 255) rx_count++;
      rx_in_cycle = 1'b0;
    end
    if ((t - rx_win_t) > TIME_W'(cfg_window) && rx_count > 0) begin
      rx_in_cycle = 1'b0;
      if (rx_count < int'(CNT_MIN)) begin
        sym = 2'd0;
        rx_clamp = 1'b1;
      end else if (rx_count > int'(CNT_MAX)) begin
        sym = 2'd3;
        rx_clamp = 1'b1;
      end else begin
        sym = 2'(rx_count - 2);
      end
      rx_word   = {rx_word[OUT_WORD_W-3:0], sym};
      rx_count  = 0;
      rx_bits   += 2;
      rx_last_t = t;
    end
    rx_prev = rd;
    if (rx_bits >= frame_bits()) end_frame(ST_DONE, rx_word, rx_clamp);
  endtask

  // sample driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) track_sample(in_ch.action, in_ch.reading, in_ch.now_us);
      if (!in_ch.valid || in_ch.ready) begin
        if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_sample = sample_queue.pop_front();
          in_ch.valid   <= 1'b1;
          in_ch.action  <= next_sample.act;
          in_ch.reading <= next_sample.rd;
          in_ch.now_us  <= next_sample.t;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (frame_results_due.size() == 0) begin
          $error("result item with nothing expected: status %0d word %h clamped %0d",
                 out_ch.status, out_ch.word, out_ch.clamped);
          fail_count++;
        end else begin
          want = frame_results_due.pop_front();
          if (out_ch.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, out_ch.status);
            fail_count++;
          end
          if (out_ch.word !== want.word) begin
            $error("word expected %h got %h", want.word, out_ch.word);
            fail_count++;
          end
          if (out_ch.clamped !== want.clamped) begin
            $error("clamped expected %0d got %0d", want.clamped, out_ch.clamped);
            fail_count++;
          end
        end
      end
      if (hold_req && !hold_started) begin
        hold_started <= 1'b1;
        hold_left    <= HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no >= CYCLE_LIMIT) begin
      $display("fsk_cycle_count_demodulator: mismatch");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_SLOPE:    cfg_slope    = val[THR_W-1:0];
      REG_WINDOW:   cfg_window   = val[WIN_W-1:0];
      REG_START_TO: cfg_start_to = val[TIME_W-1:0];
      REG_GAP_TO:   cfg_gap_to   = val[TIME_W-1:0];
      REG_BITS:     cfg_bits     = val[BPF_W-1:0];
      default: ;
    endcase
  endtask

  // narrow registers get junk above their width
  task automatic set_regs(input logic [31:0] slope, input logic [31:0] win,
                          input logic [31:0] sto, input logic [31:0] gto,
                          input logic [31:0] bpf);
    write_reg(REG_SLOPE, slope | ($urandom << THR_W));
    write_reg(REG_WINDOW, win | ($urandom << WIN_W));
    write_reg(REG_START_TO, sto);
    write_reg(REG_GAP_TO, gto);
    write_reg(REG_BITS, bpf | ($urandom << BPF_W));
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (sample_queue.size() != 0 || in_ch.valid || frame_results_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_sample(input logic act, input logic [RD_W-1:0] rd,
                             input logic [TIME_W-1:0] t);
    sample_item_t s;
    s.act = act;
    s.rd  = rd;
    s.t   = t;
    sample_queue.push_back(s);
    gen_count++;
  endtask

  function automatic logic [RD_W-1:0] hi_level();
    return RD_W'($urandom_range(700, 1023));
  endfunction

  function automatic logic [RD_W-1:0] lo_level();
    return RD_W'($urandom_range(0, 300));
  endfunction

  // k pulses, then one quiet sample past the window
  task automatic gen_symbol(input int k, input int dt);
    for (int i = 0; i < k; i++) begin
      t_us = t_us + TIME_W'(dt);
      push_sample(1'b0, hi_level(), t_us);
      t_us = t_us + TIME_W'(dt);
      push_sample(1'b0, lo_level(), t_us);
    end
    t_us = t_us + TIME_W'(cfg_window) + 1 + $urandom_range(0, 3);
    push_sample(1'b0, lo_level(), t_us);
  endtask

  task automatic gen_frame();
    int nsym;
    int k;
    int dt;
    nsym = (frame_bits() + 1) / 2;
    dt = (cfg_window >= 32) ? $urandom_range(1, cfg_window / 16) : 1;
    t_us = t_us + $urandom_range(1, 5);
    push_sample(1'b1, lo_level(), t_us);
    for (int i = 0; i < nsym; i++) begin
      // occasionally cut the frame short
      if ($urandom_range(19) == 0) break;
      if ($urandom_range(4) == 0)
        k = $urandom_range(1) ? $urandom_range(0, 1) : $urandom_range(6, 7);
      else
        k = $urandom_range(2, 5);
      gen_symbol(k, dt);
    end
  endtask

  task automatic gen_stall();
    t_us = t_us + $urandom_range(1, 5);
    push_sample(1'b1, lo_level(), t_us);
    if ($urandom_range(1)) gen_symbol($urandom_range(2, 5), 1);
    t_us = t_us + $urandom;
    push_sample(1'b0, RD_W'($urandom_range(0, 1023)), t_us);
    t_us = t_us + 1;
    push_sample(1'b0, lo_level(), t_us);
  endtask

  task automatic gen_noise();
    for (int i = 0; i < 8; i++) begin
      t_us = t_us + $urandom_range(0, 40);
      push_sample($urandom_range(7) == 0, RD_W'($urandom_range(0, 1023)), t_us);
    end
  endtask

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  initial begin
    int pick;
    logic [31:0] win;
    in_ch.valid    = 1'b0;
    in_ch.action   = 1'b0;
    in_ch.reading  = '0;
    in_ch.now_us   = '0;
    out_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = '0;
    cfg_ch.data    = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed items at reset settings
    @(negedge clk);
    set_idle(20, 63);
    push_sample(1'b0, 10'd1023, 32'hFFFF_FFFF);       // sample with no frame open
    push_sample(1'b1, 10'd0, 32'hFFFF_FF00);
    push_sample(1'b0, 10'd1023, 32'hFFFF_FF10);
    push_sample(1'b0, 10'd0, 32'hFFFF_FF20);
    push_sample(1'b0, 10'd1023, 32'hFFFF_FF30);
    push_sample(1'b0, 10'd0, 32'hFFFF_FF40);
    push_sample(1'b0, 10'd0, 32'hFFFF_FF00 + 32'd9800);  // window closes across the wrap
    push_sample(1'b1, 10'd512, 32'd0);                // restart while active
    push_sample(1'b0, 10'd600, 32'd1000001);          // no signal timeout
    push_sample(1'b0, 10'd700, 32'd1000002);
    push_sample(1'b1, 10'd100, 32'd2000000);
    push_sample(1'b0, 10'd900, 32'd2000010);
    push_sample(1'b0, 10'd100, 32'd2000020);
    push_sample(1'b0, 10'd100, 32'd2009800);          // single cycle, clamped low
    push_sample(1'b0, 10'd100, 32'd2309801);          // gap timeout
    push_sample(1'b1, 10'd0, 32'd3000000);
    push_sample(1'b0, 10'd50, 32'd4000000);           // exactly at the start limit
    push_sample(1'b0, 10'd50, 32'd4000001);
    push_sample(1'b1, 10'd1023, 32'd4000002);
    push_sample(1'b0, 10'd0, 32'd4000003);
    wait_idle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: set_regs(32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
        1: begin
          set_regs(32'd1023, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd63);
          write_reg(REG_NONE, $urandom);
        end
        2: set_regs(32'd380, 32'd64, 32'd5000, 32'd100, 32'd33);
        3: set_regs(32'd150, 32'd1, 32'd3000, 32'hFFFF_FFFF, 32'd32);
        4: set_regs(32'd200, 32'd1000000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd2);
        default: begin
          win = $urandom_range(1, 300);
          set_regs($urandom_range(0, 380), win, $urandom_range(20, 3000),
                   $urandom_range(win, win * 4 + 200),
                   ($urandom_range(4) == 0) ? $urandom_range(0, 63)
                                            : 2 * $urandom_range(1, 8));
        end
      endcase
      @(negedge clk);
      if (p < 5) set_idle(20, 63);
      else if (p < 10) set_idle(63, 20);
      else set_idle(0, 0);
      if ($urandom_range(2) == 0) t_us = $urandom;
      gen_count = 0;
      while (gen_count < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 70) gen_frame();
        else if (pick < 85) gen_stall();
        else gen_noise();
      end
      wait_idle();
    end

    // every start item ends a frame: the receiver holds off while items keep coming
    set_regs(32'd150, 32'd100, 32'd1000, 32'd1000, 32'd0);
    @(negedge clk);
    set_idle(0, 0);
    hold_req = 1'b1;
    for (int i = 0; i < 60; i++) begin
      t_us = t_us + $urandom_range(0, 9);
      push_sample($urandom_range(3) != 0, RD_W'($urandom_range(0, 1023)), t_us);
    end
    wait_idle();

    // one symbol long enough to saturate the cycle count
    set_regs(32'd150, 32'd2000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd2);
    @(negedge clk);
    t_us = t_us + 1;
    push_sample(1'b1, lo_level(), t_us);
    gen_symbol(260, 1);
    wait_idle();

    if (fail_count == 0) begin
      $display("fsk_cycle_count_demodulator: match");
    end else begin
      $display("fsk_cycle_count_demodulator: mismatch");
    end
    $finish;
  end
endmodule
